// File: rtl/ghbc_pkg.sv
// ----------------------------------------------------------------------------
// ghbc_pkg: shared types and constants for the ghost boundary closer
// Sizes of the side and region stores, field widths, codes and the small
// modulo-three helper used by the next-side rule.
// ----------------------------------------------------------------------------
package ghbc_pkg;

	localparam int MAX_SIDES   = 8192;
	localparam int MAX_REGIONS = 2048;

	localparam int SIDE_W   = $clog2(MAX_SIDES);
	localparam int CNT_W    = SIDE_W + 1;
	localparam int RING_W   = CNT_W + 2;
	localparam int REGMAP_W = $clog2(MAX_REGIONS);
	localparam int REGION_W = 11;
	localparam int OPP_W    = 14;
	localparam int STAT_W   = 2;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVF   = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

	typedef enum logic [10:0] {
		S_IDLE   = 11'b00000000001,
		S_RD     = 11'b00000000010,
		S_SCAN_A = 11'b00000000100,
		S_SCAN_B = 11'b00000001000,
		S_FIT    = 11'b00000010000,
		S_G0     = 11'b00000100000,
		S_G1     = 11'b00001000000,
		S_G2     = 11'b00010000000,
		S_G3     = 11'b00100000000,
		S_G4     = 11'b01000000000,
		S_G5     = 11'b10000000000
	} state_t;

	localparam int DIG_N = (SIDE_W + 1) / 2;

	// x mod 3: 4**k is 1 mod 3, so base-4 digits just add up
	function automatic logic [1:0] mod3(input logic [SIDE_W-1:0] x);
		logic [2*DIG_N-1:0] xp;
		logic [7:0]         sum;
		logic [2:0]         f1;
		logic [2:0]         f2;
		xp  = (2*DIG_N)'(x);
		sum = 8'd0;
		for (int d = 0; d < DIG_N; d++) begin
			sum = sum + 8'(xp[2*d +: 2]);
		end
		f1 = 3'(sum[1:0]) + 3'(sum[3:2]) + 3'(sum[5:4]) + 3'(sum[7:6]);
		f2 = 3'(f1[1:0]) + 3'(f1[2]);
		f2 = 3'(f2[1:0]) + 3'(f2[2]);
		if (f2 >= 3'd3) begin
			f2 = f2 - 3'd3;
		end
		return f2[1:0];
	endfunction

endpackage

// File: rtl/ghbc_ram.sv
// ----------------------------------------------------------------------------
// ghbc_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ghbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/half_edge_ghost_boundary_closer.sv
// ----------------------------------------------------------------------------
// half_edge_ghost_boundary_closer
// Loads solid half-edges, closes the boundary with a ring of ghost triangles
// and serves reads of the extended side arrays.
// ----------------------------------------------------------------------------
// A load is accepted in the idle state. A read moves to the read state, which
// it leaves once the output register is free. The item that carries last
// starts the closure, during which in_stall is high: a scan of every solid
// side and a closing step, the fit check, then the states G0 to G5 for each
// unpaired side. The boundary walk reads through the single read port of each
// side store. A load after a finished closure starts a new mesh. Stores need
// no clearing after reset.
module half_edge_ghost_boundary_closer
	import ghbc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [REGION_W-1:0]        cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       op,
	input  logic [SIDE_W-1:0]          side_index,
	input  logic [REGION_W-1:0]        start_region,
	input  logic signed [OPP_W-1:0]    opposite_side,
	input  logic                       last,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [REGION_W-1:0]        out_start_region,
	output logic signed [OPP_W-1:0]    out_opposite_side,
	output logic [CNT_W-1:0]           total_sides,
	output logic [CNT_W-1:0]           unpaired_sides,
	output logic [STAT_W-1:0]          status
);

	state_t              state_q;
	logic [REGION_W-1:0] ghost_q;
	logic [CNT_W-1:0]    solid_q, unp_q, i_q, cnt_q, g_q, koff_q;
	logic [RING_W-1:0]   ring_q;
	logic [SIDE_W-1:0]   first_q, s_q, snext_q, rd_idx_q;
	logic [REGION_W-1:0] r_q, st_q;
	logic                closed_q, ovf_q, nxt_oor_q, rd_oor_q, out_valid_q;
	logic [REGION_W-1:0] out_st_q;
	logic [OPP_W-1:0]    out_opp_q;
	logic [CNT_W-1:0]    out_tot_q, out_unp_q;
	logic [STAT_W-1:0]   out_stat_q;

	logic                  st_we, opp_we, rm_we;
	logic [SIDE_W-1:0]     st_wa, st_ra, opp_wa, opp_ra;
	logic [REGION_W-1:0]   st_wd, st_rd;
	logic [OPP_W-1:0]      opp_wd, opp_rd;
	logic [REGMAP_W-1:0]   rm_wa, rm_ra;
	logic [SIDE_W-1:0]     rm_wd, rm_rd;

	logic                in_xfer, out_xfer;
	logic [CNT_W-1:0]    eff_solid;
	logic                fits;
	logic [RING_W:0]     total_now, fit_total;
	logic [CNT_W-1:0]    nxt;
	logic [CNT_W-1:0]    g1, g2, k_abs;
	logic [RING_W-1:0]   koff_inc;

	assign in_stall  = !(state_q == S_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign eff_solid = closed_q ? '0 : solid_q;
	assign fits      = eff_solid < CNT_W'(MAX_SIDES);
	assign total_now = (RING_W+1)'(solid_q) + (RING_W+1)'(unp_q)
			+ ((RING_W+1)'(unp_q) << 1);
	assign fit_total = (RING_W+1)'(solid_q) + (RING_W+1)'(cnt_q)
			+ ((RING_W+1)'(cnt_q) << 1);
	assign nxt       = (mod3(s_q) == 2'd2) ? (CNT_W'(s_q) - CNT_W'(2))
			: (CNT_W'(s_q) + CNT_W'(1));
	assign g1        = g_q + CNT_W'(1);
	assign g2        = g_q + CNT_W'(2);
	assign k_abs     = solid_q + koff_q;
	assign koff_inc  = RING_W'(koff_q) + RING_W'(3);

	always_comb begin
		st_we  = 1'b0;
		st_wa  = eff_solid[SIDE_W-1:0];
		st_wd  = start_region;
		st_ra  = side_index;
		opp_we = 1'b0;
		opp_wa = eff_solid[SIDE_W-1:0];
		opp_wd = opposite_side;
		opp_ra = side_index;
		rm_we  = 1'b0;
		rm_wa  = st_rd[REGMAP_W-1:0];
		rm_wd  = i_q[SIDE_W-1:0];
		rm_ra  = r_q[REGMAP_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_xfer && op == OP_LOAD && fits) begin
					st_we  = 1'b1;
					opp_we = 1'b1;
				end
			end
			S_RD: begin
				st_ra  = rd_idx_q;
				opp_ra = rd_idx_q;
			end
			S_SCAN_A: begin
				st_ra  = i_q[SIDE_W-1:0];
				opp_ra = i_q[SIDE_W-1:0];
			end
			S_SCAN_B: begin
				rm_we = opp_rd[OPP_W-1] && (32'(st_rd) < MAX_REGIONS);
			end
			S_G0: st_ra = nxt[SIDE_W-1:0];
			S_G1: st_ra = s_q;
			S_G2: begin
				opp_we = 1'b1;
				opp_wa = s_q;
				opp_wd = OPP_W'(g_q);
			end
			S_G3: begin
				opp_we = 1'b1;
				opp_wa = g_q[SIDE_W-1:0];
				opp_wd = OPP_W'(s_q);
				st_we  = 1'b1;
				st_wa  = g_q[SIDE_W-1:0];
				st_wd  = r_q;
			end
			S_G4: begin
				st_we  = 1'b1;
				st_wa  = g1[SIDE_W-1:0];
				st_wd  = st_q;
				opp_we = 1'b1;
				opp_wa = g2[SIDE_W-1:0];
				opp_wd = OPP_W'(k_abs);
			end
			S_G5: begin
				st_we  = 1'b1;
				st_wa  = g2[SIDE_W-1:0];
				st_wd  = ghost_q;
				opp_we = 1'b1;
				opp_wa = k_abs[SIDE_W-1:0];
				opp_wd = OPP_W'(g2);
			end
			default: begin
			end
		endcase
	end

	ghbc_ram #(.WIDTH(REGION_W), .DEPTH(MAX_SIDES)) u_start_ram (
		.clk(clk), .we(st_we), .waddr(st_wa), .wdata(st_wd),
		.raddr(st_ra), .rdata(st_rd)
	);

	ghbc_ram #(.WIDTH(OPP_W), .DEPTH(MAX_SIDES)) u_opp_ram (
		.clk(clk), .we(opp_we), .waddr(opp_wa), .wdata(opp_wd),
		.raddr(opp_ra), .rdata(opp_rd)
	);

	ghbc_ram #(.WIDTH(SIDE_W), .DEPTH(MAX_REGIONS)) u_region_ram (
		.clk(clk), .we(rm_we), .waddr(rm_wa), .wdata(rm_wd),
		.raddr(rm_ra), .rdata(rm_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ghost_q     <= '0;
			solid_q     <= '0;
			unp_q       <= '0;
			first_q     <= '0;
			closed_q    <= 1'b0;
			ovf_q       <= 1'b0;
			i_q         <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				ghost_q <= cfg_wdata;
			end
			// in S_RD the output register is reloaded or held below
			if (out_xfer && state_q != S_RD) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer && op == OP_LOAD) begin
						solid_q  <= eff_solid + CNT_W'(fits);
						ovf_q    <= !fits || (ovf_q && !closed_q);
						closed_q <= 1'b0;
						if (closed_q) begin
							unp_q   <= '0;
						end
						if (closed_q || last) begin
							first_q <= '0;
						end
						if (last) begin
							i_q     <= '0;
							cnt_q   <= '0;
							state_q <= S_SCAN_A;
						end
					end else if (in_xfer) begin
						rd_idx_q <= side_index;
						rd_oor_q <= (RING_W+1)'(side_index) >= total_now;
						state_q  <= S_RD;
					end
				end
				S_RD: begin
					if (!(out_valid_q && out_stall)) begin
						out_valid_q <= 1'b1;
						out_st_q    <= rd_oor_q ? '0 : st_rd;
						out_opp_q   <= rd_oor_q ? '1 : opp_rd;
						out_tot_q   <= total_now[CNT_W-1:0];
						out_unp_q   <= unp_q;
						out_stat_q  <= rd_oor_q ? ST_RANGE : (ovf_q ? ST_OVF : ST_OK);
						state_q     <= S_IDLE;
					end
				end
				S_SCAN_A: begin
					state_q <= (i_q == solid_q) ? S_FIT : S_SCAN_B;
				end
				S_SCAN_B: begin
					if (opp_rd[OPP_W-1]) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						first_q <= i_q[SIDE_W-1:0];
					end
					i_q     <= i_q + CNT_W'(1);
					state_q <= S_SCAN_A;
				end
				S_FIT: begin
					closed_q <= 1'b1;
					if (fit_total > (RING_W+1)'(MAX_SIDES)) begin
						ovf_q   <= 1'b1;
						unp_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						unp_q  <= cnt_q;
						s_q    <= first_q;
						g_q    <= solid_q;
						i_q    <= '0;
						ring_q <= fit_total[RING_W-1:0] - RING_W'(solid_q);
						// ring of three wraps the offset of four round to one
						koff_q <= (cnt_q == CNT_W'(1)) ? CNT_W'(1) : CNT_W'(4);
						state_q <= (cnt_q == '0) ? S_IDLE : S_G0;
					end
				end
				S_G0: begin
					nxt_oor_q <= nxt[SIDE_W];
					state_q   <= S_G1;
				end
				S_G1: begin
					r_q     <= nxt_oor_q ? '0 : st_rd;
					state_q <= S_G2;
				end
				S_G2: begin
					st_q    <= st_rd;
					state_q <= S_G3;
				end
				S_G3: begin
					snext_q <= (32'(r_q) < MAX_REGIONS) ? rm_rd : '0;
					state_q <= S_G4;
				end
				S_G4: begin
					state_q <= S_G5;
				end
				S_G5: begin
					s_q    <= snext_q;
					g_q    <= g_q + CNT_W'(3);
					koff_q <= (koff_inc >= ring_q) ? CNT_W'(koff_inc - ring_q)
							: CNT_W'(koff_inc);
					i_q    <= i_q + CNT_W'(1);
					state_q <= (i_q + CNT_W'(1) == unp_q) ? S_IDLE : S_G0;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid         = out_valid_q;
	assign out_start_region  = out_st_q;
	assign out_opposite_side = out_opp_q;
	assign total_sides       = out_tot_q;
	assign unpaired_sides    = out_unp_q;
	assign status            = out_stat_q;

	a_onehot_state: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_rd_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && in_valid && op == OP_READ) |=> (state_q == S_RD))
		else $error("read transfer did not enter read state");

	a_ghost_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_G5) |-> (32'(g2) < MAX_SIDES && 32'(k_abs) < MAX_SIDES))
		else $error("ghost side index beyond store");

	a_ring_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_G4) |-> (RING_W'(koff_q) < ring_q))
		else $error("ring offset not below ring size");

endmodule

// File: verif/ghbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ghbc_checker: predictor and scoreboard for the ghost boundary closer
// Watches the configuration port and both channels, keeps its own copy of the
// side stores and the region map, closes the mesh on the last load and
// compares every read transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ghbc_checker
	import ghbc_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REGION_W-1:0]     cfg_wdata,
	input  logic                    in_valid,
	input  logic                    in_stall,
	input  logic                    op,
	input  logic [SIDE_W-1:0]       side_index,
	input  logic [REGION_W-1:0]     start_region,
	input  logic signed [OPP_W-1:0] opposite_side,
	input  logic                    last,
	input  logic                    out_valid,
	input  logic                    out_stall,
	input  logic [REGION_W-1:0]     out_start_region,
	input  logic signed [OPP_W-1:0] out_opposite_side,
	input  logic [CNT_W-1:0]        total_sides,
	input  logic [CNT_W-1:0]        unpaired_sides,
	input  logic [STAT_W-1:0]       status,
	output int                      errors,
	output int                      outstanding
);

	typedef struct packed {
		logic [REGION_W-1:0] start_r;
		logic [OPP_W-1:0]    opp;
		logic [CNT_W-1:0]    total;
		logic [CNT_W-1:0]    unpaired;
		logic [STAT_W-1:0]   stat;
	} side_read_t;

	logic [REGION_W-1:0] start_mem [MAX_SIDES];
	logic [OPP_W-1:0]    opp_mem   [MAX_SIDES];
	int unsigned         region_map [MAX_REGIONS];
	int unsigned         n_solid;
	int unsigned         n_unpaired;
	int unsigned         first_unp;
	bit                  ovf;
	bit                  is_closed;
	logic [REGION_W-1:0] ghost_r;
	side_read_t          read_q [$];

	function automatic int unsigned next_in_tri(int unsigned s);
		return (s % 3 == 2) ? s - 2 : s + 1;
	endfunction

	function automatic int unsigned start_of(int unsigned s);
		return (s < MAX_SIDES) ? int'(start_mem[s]) : 0;
	endfunction

	task automatic put_start(int unsigned s, int unsigned v);
		if (s < MAX_SIDES) start_mem[s] = v[REGION_W-1:0];
	endtask

	task automatic put_opp(int unsigned s, int unsigned v);
		if (s < MAX_SIDES) opp_mem[s] = v[OPP_W-1:0];
	endtask

	task automatic close_boundary();
		int unsigned cnt, first, s, ring, g, k, r;
		cnt = 0;
		first = 0;
		for (int unsigned i = 0; i < n_solid; i++) begin
			if (opp_mem[i][OPP_W-1]) begin
				cnt++;
				if (start_mem[i] < MAX_REGIONS) region_map[start_mem[i]] = i;
				first = i;
			end
		end
		first_unp = first;
		is_closed = 1;
		if (n_solid + 3 * cnt > MAX_SIDES) begin
			ovf = 1;
			n_unpaired = 0;
			return;
		end
		n_unpaired = cnt;
		s = first;
		ring = 3 * cnt;
		for (int unsigned i = 0; i < cnt; i++) begin
			g = n_solid + 3 * i;
			k = n_solid + (3 * i + 4) % ring;
			r = start_of(next_in_tri(s));
			put_opp(s, g);
			put_opp(g, s);
			put_start(g, r);
			put_start(g + 1, start_of(s));
			put_start(g + 2, ghost_r);
			put_opp(g + 2, k);
			put_opp(k, g + 2);
			s = (r < MAX_REGIONS) ? region_map[r] : 0;
		end
	endtask

	task automatic accept_item();
		side_read_t exp_r;
		int unsigned total;
		if (op == OP_LOAD) begin
			if (is_closed) begin
				n_solid = 0;
				n_unpaired = 0;
				first_unp = 0;
				ovf = 0;
				is_closed = 0;
			end
			if (n_solid < MAX_SIDES) begin
				start_mem[n_solid] = start_region;
				opp_mem[n_solid] = opposite_side;
				n_solid++;
			end else begin
				ovf = 1;
			end
			if (last) close_boundary();
		end else begin
			total = n_solid + 3 * n_unpaired;
			exp_r.total = total[CNT_W-1:0];
			exp_r.unpaired = n_unpaired[CNT_W-1:0];
			if (side_index >= total) begin
				exp_r.start_r = '0;
				exp_r.opp = '1;
				exp_r.stat = ST_RANGE;
			end else begin
				exp_r.start_r = start_mem[side_index];
				exp_r.opp = opp_mem[side_index];
				exp_r.stat = ovf ? ST_OVF : ST_OK;
			end
			read_q.push_back(exp_r);
		end
	endtask

	task automatic check_read();
		side_read_t exp_r, got;
		got = {out_start_region, out_opposite_side, total_sides, unpaired_sides, status};
		if (read_q.size() == 0) begin
			errors++;
			if (errors <= 10) $display("ERROR: unexpected read transfer %h", got);
			return;
		end
		exp_r = read_q.pop_front();
		if (got !== exp_r) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: read mismatch exp st=%0d opp=%0d tot=%0d unp=%0d stat=%0d, got st=%0d opp=%0d tot=%0d unp=%0d stat=%0d",
					exp_r.start_r, $signed(exp_r.opp), exp_r.total, exp_r.unpaired,
					exp_r.stat, got.start_r, $signed(got.opp), got.total, got.unpaired,
					got.stat);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_solid = 0;
			n_unpaired = 0;
			first_unp = 0;
			ovf = 0;
			is_closed = 0;
			ghost_r = '0;
			read_q.delete();
			errors = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) check_read();
			if (in_valid && !in_stall) accept_item();
			if (cfg_we) ghost_r = cfg_wdata;
			outstanding = read_q.size();
		end
	end

	final begin
		if (read_q.size() != 0) $display("ERROR: %0d reads never returned", read_q.size());
	end

endmodule

// File: verif/tb_half_edge_ghost_boundary_closer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_half_edge_ghost_boundary_closer: stimulus and verdict
// Loads fan meshes with open boundaries, closed-up meshes, all-open runs
// and random reads, under random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_half_edge_ghost_boundary_closer;
	import ghbc_pkg::*;

	localparam int IDLE_LIMIT = 100000;
	localparam int RAND_ITEMS = 820;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [REGION_W-1:0]     cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic                    op;
	logic [SIDE_W-1:0]       side_index;
	logic [REGION_W-1:0]     start_region;
	logic signed [OPP_W-1:0] opposite_side;
	logic                    last;
	logic                    out_valid;
	logic                    out_stall;
	logic [REGION_W-1:0]     out_start_region;
	logic signed [OPP_W-1:0] out_opposite_side;
	logic [CNT_W-1:0]        total_sides;
	logic [CNT_W-1:0]        unpaired_sides;
	logic [STAT_W-1:0]       status;
	int                      errors;
	int                      outstanding;
	int                      idle_cycles;
	int                      sent;
	bit                      tx_quiet;
	bit                      rx_quiet;
	bit                      long_hold;

	half_edge_ghost_boundary_closer uut (.*);
	ghbc_checker chk (.*);

	initial clk = 0;
	always #10 clk = ~clk;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random stalls, quiet stretches and one long hold
	initial begin
		int left;
		left = 0;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				long_hold = 0;
				out_stall <= 0;
			end else if (rx_quiet) begin
				out_stall <= 0;
			end else if (left > 0) begin
				left--;
			end else if ($urandom_range(0, 9) < 3) begin
				left = gap_len();
				out_stall <= (left > 0);
			end else begin
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send(logic o, logic [SIDE_W-1:0] idx, logic [REGION_W-1:0] reg_v,
			logic signed [OPP_W-1:0] opp, logic lst);
		int g;
		in_valid <= 1;
		op <= o;
		side_index <= idx;
		start_region <= reg_v;
		opposite_side <= opp;
		last <= lst;
		do @(posedge clk); while (in_stall);
		sent++;
		g = tx_quiet ? 0 : gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic read_side(int idx);
		send(OP_READ, idx[SIDE_W-1:0], REGION_W'($urandom), OPP_W'($urandom),
			1'($urandom_range(0, 1)));
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ghost(logic [REGION_W-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic signed [OPP_W-1:0] boundary_opp();
		return OPP_W'($urandom_range(8192, 16383));
	endfunction

	// open fan of m triangles around one center: boundary is a single ring
	task automatic load_fan(int m, int n_reads);
		int base, stride, total;
		logic [REGION_W-1:0] c, a, b;
		logic signed [OPP_W-1:0] o0, o2;
		base = $urandom_range(0, 2047);
		stride = 2 * $urandom_range(0, 1023) + 1;
		c = REGION_W'(base);
		for (int t = 0; t < m; t++) begin
			a = REGION_W'(base + (t + 1) * stride);
			b = REGION_W'(base + (t + 2) * stride);
			o0 = (t > 0) ? OPP_W'(3 * (t - 1) + 2) : boundary_opp();
			o2 = (t < m - 1) ? OPP_W'(3 * (t + 1)) : boundary_opp();
			send(OP_LOAD, SIDE_W'($urandom), c, o0, 1'b0);
			if ($urandom_range(0, 9) == 0) read_side($urandom_range(0, 3 * t));
			send(OP_LOAD, SIDE_W'($urandom), a, boundary_opp(), 1'b0);
			send(OP_LOAD, SIDE_W'($urandom), b, o2, t == m - 1);
		end
		total = 3 * m + 3 * (m + 2);
		for (int i = 0; i < n_reads; i++) begin
			if ($urandom_range(0, 7) == 0) read_side($urandom_range(0, 8191));
			else read_side($urandom_range(0, total + 1));
		end
	endtask

	// one triangle with every side paired: closure builds no ghost
	task automatic load_paired_tri(int n_reads);
		for (int i = 0; i < 3; i++)
			send(OP_LOAD, SIDE_W'($urandom), REGION_W'($urandom),
				OPP_W'($urandom_range(0, 8191)), i == 2);
		for (int i = 0; i < n_reads; i++) read_side($urandom_range(0, 4));
	endtask

	// whole triangles with every side open: each side gets a ghost
	task automatic load_unpaired_run(int n);
		for (int i = 0; i < n; i++)
			send(OP_LOAD, SIDE_W'($urandom), REGION_W'($urandom), boundary_opp(),
				i == n - 1);
		read_side(0);
		read_side(n - 1);
		read_side(8191);
	endtask

	initial begin
		int m;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_valid = 0;
		op = OP_LOAD;
		side_index = '0;
		start_region = '0;
		opposite_side = '0;
		last = 0;
		tx_quiet = 0;
		rx_quiet = 0;
		long_hold = 0;
		sent = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: reads before any load, one triangle, closed triangle
		write_ghost(11'd2047);
		read_side(0);
		read_side(8191);
		send(OP_LOAD, 13'd8191, 11'd0, -14'sd1, 1'b0);
		read_side(0);
		send(OP_LOAD, 13'd0, 11'd2047, OPP_W'(-8192), 1'b0);
		send(OP_LOAD, 13'd0, 11'd5, -14'sd1, 1'b1);
		for (int i = 0; i <= 12; i++) read_side(i);
		load_paired_tri(2);
		drain();

		// all-open runs back to back
		write_ghost(11'd0);
		tx_quiet = 1;
		load_unpaired_run(6);
		load_unpaired_run(3);
		tx_quiet = 0;
		drain();

		// receiver holds while reads keep coming
		load_fan(3, 0);
		long_hold = 1;
		tx_quiet = 1;
		for (int i = 0; i < 20; i++) read_side($urandom_range(0, 20));
		tx_quiet = 0;
		drain();

		sent = 0;
		while (sent < RAND_ITEMS) begin
			tx_quiet = ($urandom_range(0, 9) == 0);
			rx_quiet = ($urandom_range(0, 9) == 0);
			m = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			case ($urandom_range(0, 9))
				0: load_paired_tri($urandom_range(1, 4));
				1: for (int i = 0; i < 5; i++) read_side($urandom_range(0, 8191));
				default: load_fan(m, $urandom_range(2, 10));
			endcase
			if ($urandom_range(0, 7) == 0) begin
				drain();
				write_ghost($urandom_range(0, 1) ? REGION_W'($urandom) : 11'd2047);
			end
		end
		tx_quiet = 0;
		rx_quiet = 0;
		drain();
		repeat (20) @(posedge clk);
		if (errors == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
